// ===== rtl/core/nta_pkg.sv =====
package nta_pkg;

    localparam int unsigned VALUE_W = 32;
    localparam int unsigned OP_W    = 2;
    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned BCD_DIGITS = 10;
    localparam int unsigned DIG_W   = 4 * BCD_DIGITS;
    localparam int unsigned CNT_W   = 6;

    typedef enum logic [OP_W-1:0] {
        OP_BIN     = 2'd0,
        OP_HEX     = 2'd1,
        OP_DEC     = 2'd2,
        OP_DEC_SWP = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PFX0,
        S_PFXC,
        S_CONV,
        S_SKIP,
        S_EMIT,
        S_NL
    } state_t;

    localparam logic [CHAR_W-1:0] ASCII_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] ASCII_B    = 8'h62;
    localparam logic [CHAR_W-1:0] ASCII_X    = 8'h78;
    localparam logic [CHAR_W-1:0] ASCII_NL   = 8'h0a;
    localparam logic [CHAR_W-1:0] ASCII_A_M10 = 8'h57;

    function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [3:0] d);
        logic [CHAR_W-1:0] ext;
        ext = {4'b0000, d};
        if (d < 4'd10)
            return ASCII_ZERO + ext;
        else
            return ASCII_A_M10 + ext;
    endfunction

endpackage

// ===== rtl/core/nta_if.sv =====
interface nta_num_if;
    import nta_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [VALUE_W-1:0]   value;
    logic [OP_W-1:0]      operation;

    modport source (output valid, output value, output operation, input ready);
    modport sink   (input valid, input value, input operation, output ready);
endinterface

interface nta_char_if;
    import nta_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CHAR_W-1:0]    character;
    logic                 last;

    modport source (output valid, output character, output last, input ready);
    modport sink   (input valid, input character, input last, output ready);
endinterface

// ===== rtl/core/number_to_ascii_formatter.sv =====
// Number-to-ASCII formatter.
//
// Channels: "number" takes one beat holding a 32-bit value and a 2-bit
// operation (binary, hex, decimal, byte-swapped decimal). "text" returns one
// beat per ASCII character; the final beat of each item is a newline with
// last set. Binary and hex answers open with "0b" / "0x"; leading zeros are
// dropped and a zero value prints a single "0".
//
// Timing: binary and hex digits sit in a 40-bit shift register that moves one
// digit per cycle unless an emit stalls; leading zeros are skipped at one digit
// per cycle, then each character leaves at one per cycle while no beat waits on
// text.ready. Decimal first runs a bit-serial shift-and-add-3 conversion, one
// input bit per cycle, then the same skip/emit walk over ten BCD digits. One
// item is in work at a time; number.ready is high only between items, so the
// next value is taken in the cycle after the newline enters the output register.
//
// A single output register holds the current character; while it holds a beat
// and text.ready is low, the prefix, emit and newline steps stall and the held
// beat stays put. Reset (rst_n low, async) drops any item in work and empties the output register.
module number_to_ascii_formatter (
    input  logic            clk,
    input  logic            rst_n,
    nta_num_if.sink         number,
    nta_char_if.source      text
);
    import nta_pkg::*;

    state_t              state_reg, state_next;
    op_t                 op_reg, op_next;
    logic [DIG_W-1:0]    dig_reg, dig_next;
    logic [VALUE_W-1:0]  bin_reg, bin_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]   char_reg, char_next;
    logic                last_reg, last_next;

    logic                slot_free;
    logic                is_bin;
    logic [3:0]          cur_digit;
    logic [DIG_W-1:0]    dig_shifted;
    logic [DIG_W-1:0]    bcd_adj;
    logic [VALUE_W-1:0]  load_val;

    assign number.ready   = (state_reg == S_IDLE);
    assign text.valid     = out_valid_reg;
    assign text.character = char_reg;
    assign text.last      = last_reg;

    assign slot_free = !out_valid_reg || text.ready;
    assign is_bin    = (op_reg == OP_BIN);
    assign cur_digit = is_bin ? {3'b000, dig_reg[DIG_W-1]} : dig_reg[DIG_W-1 -: 4];
    assign dig_shifted = is_bin ? {dig_reg[DIG_W-2:0], 1'b0}
                                : {dig_reg[DIG_W-5:0], 4'b0000};

    // Swap bytes for the swapped-decimal operation.
    assign load_val = (op_t'(number.operation) == OP_DEC_SWP)
        ? {number.value[7:0], number.value[15:8], number.value[23:16], number.value[31:24]}
        : number.value;

    // Add 3 to every BCD digit of 5 or more before each shift.
    always_comb
    begin
        for (int i = 0; i < BCD_DIGITS; i++)
        begin
            if (dig_reg[4*i +: 4] >= 4'd5)
                bcd_adj[4*i +: 4] = dig_reg[4*i +: 4] + 4'd3;
            else
                bcd_adj[4*i +: 4] = dig_reg[4*i +: 4];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        dig_next       = dig_reg;
        bin_next       = bin_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !text.ready;
        char_next      = char_reg;
        last_next      = last_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (number.valid)
                begin
                    op_next = op_t'(number.operation);
                    if (op_t'(number.operation) == OP_BIN ||
                        op_t'(number.operation) == OP_HEX)
                    begin
                        dig_next   = {number.value, 8'h00};
                        cnt_next   = (op_t'(number.operation) == OP_BIN) ? CNT_W'(32)
                                                                         : CNT_W'(8);
                        state_next = S_PFX0;
                    end
                    else
                    begin
                        dig_next   = '0;
                        bin_next   = load_val;
                        cnt_next   = CNT_W'(VALUE_W);
                        state_next = S_CONV;
                    end
                end
            end
            S_PFX0:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    char_next      = ASCII_ZERO;
                    last_next      = 1'b0;
                    state_next     = S_PFXC;
                end
            end
            S_PFXC:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    char_next      = is_bin ? ASCII_B : ASCII_X;
                    last_next      = 1'b0;
                    state_next     = S_SKIP;
                end
            end
            S_CONV:
            begin
                dig_next = {bcd_adj[DIG_W-2:0], bin_reg[VALUE_W-1]};
                bin_next = {bin_reg[VALUE_W-2:0], 1'b0};
                if (cnt_reg == CNT_W'(1))
                begin
                    cnt_next   = CNT_W'(BCD_DIGITS);
                    state_next = S_SKIP;
                end
                else
                begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            S_SKIP:
            begin
                // Drop leading zeros but always keep the final digit.
                if (cur_digit == 4'd0 && cnt_reg != CNT_W'(1))
                begin
                    dig_next = dig_shifted;
                    cnt_next = cnt_reg - CNT_W'(1);
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    char_next      = digit_to_ascii(cur_digit);
                    last_next      = 1'b0;
                    dig_next       = dig_shifted;
                    cnt_next       = cnt_reg - CNT_W'(1);
                    if (cnt_reg == CNT_W'(1))
                        state_next = S_NL;
                end
            end
            S_NL:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    char_next      = ASCII_NL;
                    last_next      = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            op_reg        <= OP_BIN;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            op_reg        <= op_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dig_reg  <= dig_next;
        bin_reg  <= bin_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    // The digit walk never runs with an empty count.
    a_emit_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT || state_reg == S_SKIP) |-> cnt_reg != '0)
        else $error("digit walk with zero count");

    // A last beat is always the newline.
    a_last_nl: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && last_reg) |-> char_reg == ASCII_NL)
        else $error("last beat is not a newline");

    // An accepted item leaves the idle state.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (number.valid && number.ready) |=> state_reg != S_IDLE)
        else $error("item accepted but block stayed idle");

    // The newline is only loaded from the newline step.
    a_nl_src: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(state_reg) != S_NL && out_valid_reg && !$past(out_valid_reg)) |-> !last_reg)
        else $error("last set outside newline step");
endmodule

// ===== tb/tb_number_to_ascii_formatter.sv =====
`timescale 1ns / 100ps

module tb_number_to_ascii_formatter;
    import nta_pkg::*;

    // Run shape. Most numbers use random gaps; one stretch runs with no idling.
    localparam int unsigned CLK_HALF       = 4;
    localparam int unsigned RESET_CYCLES   = 3;
    localparam int unsigned RANDOM_ITEMS   = 130;
    localparam int unsigned STEADY_ITEMS   = 30;
    localparam int unsigned PRESSURE_ITEMS = 6;
    localparam int unsigned HOLD_CYCLES    = 300;
    localparam int unsigned SETTLE_CYCLES  = 60;
    localparam int unsigned LIMIT_CYCLES   = 2_000_000;

    localparam logic [CHAR_W-1:0] ASCII_LOWER_A = 8'h61;

    // One character beat of the text channel.
    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              last;
    } text_beat_t;

    // Holds the characters that each accepted number must produce, oldest first,
    // and checks every text beat against them.
    class text_scoreboard;
        text_beat_t  expected_text[$];
        int unsigned err_count;
        int unsigned chars_checked;
        int unsigned numbers_noted;
        int unsigned per_op[4];

        function new();
            err_count     = 0;
            chars_checked = 0;
            numbers_noted = 0;
            foreach (per_op[i])
                per_op[i] = 0;
        endfunction

        function logic [CHAR_W-1:0] digit_char(int unsigned d);
            if (d < 10)
                return ASCII_ZERO + CHAR_W'(d);
            return ASCII_LOWER_A + CHAR_W'(d - 10);
        endfunction

        function void push_char(logic [CHAR_W-1:0] ch, logic is_last);
            text_beat_t beat;
            beat.character = ch;
            beat.last      = is_last;
            expected_text.push_back(beat);
        endfunction

        // Digits of v in the given radix, most significant first, no leading zeros.
        function void push_digits(logic [VALUE_W-1:0] v, int unsigned radix);
            logic [CHAR_W-1:0] msd_first[$];
            int unsigned       d;
            do
            begin
                d = v % radix;
                msd_first.push_front(digit_char(d));
                v = v / radix;
            end
            while (v != 0);
            foreach (msd_first[i])
                push_char(msd_first[i], 1'b0);
        endfunction

        function void note_number(logic [VALUE_W-1:0] value, op_t op);
            numbers_noted++;
            per_op[op]++;
            case (op)
                OP_BIN:
                begin
                    push_char(ASCII_ZERO, 1'b0);
                    push_char(ASCII_B, 1'b0);
                    push_digits(value, 2);
                end
                OP_HEX:
                begin
                    push_char(ASCII_ZERO, 1'b0);
                    push_char(ASCII_X, 1'b0);
                    push_digits(value, 16);
                end
                OP_DEC:
                    push_digits(value, 10);
                default:
                    push_digits({value[7:0], value[15:8], value[23:16], value[31:24]}, 10);
            endcase
            push_char(ASCII_NL, 1'b1);
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] MISMATCH: %s", $realtime, msg);
            err_count++;
        endtask

        task check_char(logic [CHAR_W-1:0] character, logic last);
            text_beat_t want;
            if (expected_text.size() == 0)
            begin
                report_mismatch($sformatf("character 0x%02h (last %0b) with nothing pending",
                                          character, last));
                return;
            end
            want = expected_text.pop_front();
            chars_checked++;
            if (character !== want.character)
                report_mismatch($sformatf("character 0x%02h, expected 0x%02h",
                                          character, want.character));
            if (last !== want.last)
                report_mismatch($sformatf("last %0b on character 0x%02h, expected %0b",
                                          last, want.character, want.last));
        endtask

        function int unsigned pending();
            return expected_text.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    nta_num_if  number_bus();
    nta_char_if text_bus();

    number_to_ascii_formatter dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .number (number_bus),
        .text   (text_bus)
    );

    text_scoreboard scoreboard;

    // Handshake knobs shared between the sender and the receiver.
    bit          hold_request = 1'b0;  // ask the receiver for one long hold-off
    bit          steady       = 1'b0;  // drop all random idling on both sides
    int unsigned cycles       = 0;

    initial
    begin
        clk = 1'b0;
        forever #(CLK_HALF) clk = ~clk;
    end

    // Watchdog: end the run once the cycle limit is reached, in case the block stops making progress.
    initial
    begin
        while (cycles < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Timeout after %0d cycles, %0d characters still pending",
                 cycles, scoreboard.pending());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Gap length: mostly from the shortest band, sometimes from the middle band, rarely from the long band.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 80)
            return $urandom_range(2, 1);
        else if (r < 95)
            return $urandom_range(8, 3);
        return $urandom_range(60, 20);
    endfunction

    // Bias values toward short digit strings and the extremes, while a large
    // share of full random words toggles every bit.
    function automatic logic [VALUE_W-1:0] pick_value();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 40)
            return $urandom();
        else if (r < 60)
            return $urandom_range(255);
        else if (r < 75)
            return 32'h1 << $urandom_range(31);
        else if (r < 88)
            return $urandom() >> $urandom_range(31);
        else if (r < 94)
            return '0;
        return '1;
    endfunction

    // Offer one number beat after an idle gap and hold it until it is taken.
    // Returns in the time step of the accepting edge, so a following beat with
    // no gap keeps valid high without lowering it.
    task automatic drive_number(logic [VALUE_W-1:0] value, op_t op, int unsigned gap);
        if (gap != 0)
        begin
            number_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        number_bus.valid     <= 1'b1;
        number_bus.value     <= value;
        number_bus.operation <= op;
        @(posedge clk);
        while (!number_bus.ready)
            @(posedge clk);
        scoreboard.note_number(value, op);
    endtask

    function automatic int unsigned sender_gap();
        if (steady || $urandom_range(1) == 0)
            return 0;
        return pick_gap();
    endfunction

    // Stop offering and wait until every expected character has come out,
    // then let the block settle.
    task automatic drain_text();
        number_bus.valid <= 1'b0;
        while (scoreboard.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_random(int unsigned count);
        for (int unsigned i = 0; i < count; i++)
            drive_number(pick_value(), op_t'($urandom_range(3)), sender_gap());
    endtask

    // Directed part: zero, one, the top bit and all ones in every format, plus
    // values that exercise the byte swap and the decimal digit boundaries.
    task automatic run_directed();
        logic [VALUE_W-1:0] edge_vals[4];
        edge_vals = '{32'h0000_0000, 32'h0000_0001, 32'h8000_0000, 32'hFFFF_FFFF};
        for (int o = 0; o < 4; o++)
            foreach (edge_vals[i])
                drive_number(edge_vals[i], op_t'(o), sender_gap());
        drive_number(32'd9, OP_DEC, sender_gap());
        drive_number(32'd1_000_000_000, OP_DEC, sender_gap());
        drive_number(32'h0100_0000, OP_DEC_SWP, sender_gap());
        drive_number(32'h0000_00FF, OP_DEC_SWP, sender_gap());
        drive_number(32'hDEAD_BEEF, OP_HEX, sender_gap());
        drive_number(32'h5555_AAAA, OP_BIN, sender_gap());
    endtask

    // Text sink: pick ready once per cycle, check each beat taken at the edge.
    initial
    begin : text_sink
        int unsigned stall_left;
        int unsigned hold_left;
        logic        take;
        stall_left = 0;
        hold_left  = 0;
        text_bus.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            // Count the long hold-off here, so the sender keeps offering meanwhile.
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                take = 1'b0;
            end
            else if (stall_left != 0)
            begin
                stall_left--;
                take = 1'b0;
            end
            else if (!steady && $urandom_range(3) == 0)
            begin
                stall_left = pick_gap() - 1;
                take       = 1'b0;
            end
            else
                take = 1'b1;
            text_bus.ready <= take;
            @(posedge clk);
            if (text_bus.valid && text_bus.ready)
                scoreboard.check_char(text_bus.character, text_bus.last);
        end
    end

    // Number source and run sequence.
    initial
    begin
        scoreboard = new();
        rst_n = 1'b0;
        number_bus.valid     <= 1'b0;
        number_bus.value     <= '0;
        number_bus.operation <= OP_BIN;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        drain_text();

        // Hold the text side off and push numbers back to back, so the output
        // register fills and the number side stalls.
        hold_request = 1'b1;
        for (int unsigned i = 0; i < PRESSURE_ITEMS; i++)
            drive_number(pick_value(), op_t'($urandom_range(3)), 0);
        drain_text();

        run_random((RANDOM_ITEMS - STEADY_ITEMS) / 2);

        // A stretch with no idling on either side.
        steady = 1'b1;
        run_random(STEADY_ITEMS);
        steady = 1'b0;

        run_random(RANDOM_ITEMS - STEADY_ITEMS - (RANDOM_ITEMS - STEADY_ITEMS) / 2);
        drain_text();

        $display("Formatted %0d numbers (binary %0d, hex %0d, decimal %0d, swapped %0d)",
                 scoreboard.numbers_noted, scoreboard.per_op[OP_BIN],
                 scoreboard.per_op[OP_HEX], scoreboard.per_op[OP_DEC],
                 scoreboard.per_op[OP_DEC_SWP]);
        $display("Checked %0d characters, with random stalls and a %0d-cycle text hold-off",
                 scoreboard.chars_checked, HOLD_CYCLES);
        if (scoreboard.err_count == 0 && scoreboard.pending() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
